[hw/rtl/tisc_pkg.sv]
// Shared types and constants for the track identity switch counter.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package tisc_pkg;

    // Store sizes.
    localparam int MAX_TRACKS = 64;
    localparam int MAX_TRUTH  = 64;
    localparam int TRK_AW     = $clog2(MAX_TRACKS);
    localparam int TRK_CW     = TRK_AW + 1;
    localparam int TRUTH_AW   = $clog2(MAX_TRUTH);

    // Field widths.
    localparam int POS_W    = 24;
    localparam int IDENT_W  = 16;
    localparam int TI_W     = 6;
    localparam int CUT_W    = 52;
    localparam int TCNT_W   = 7;
    localparam int TOTAL_W  = 32;
    localparam int DIFF_W   = POS_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;

    // One track store entry: x, y, z and identity.
    localparam int ENTRY_W  = 3 * POS_W + IDENT_W;

    // Input opcodes.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_TCOUNT = 2'd1;

    // Command queue depth.
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_ADD,
        CMD_EVAL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                  kind;
        logic signed [POS_W-1:0]    x;
        logic signed [POS_W-1:0]    y;
        logic signed [POS_W-1:0]    z;
        logic [IDENT_W-1:0]         ident;
        logic [TI_W-1:0]            ti;
    } t_cmd;

    typedef struct packed {
        logic [TI_W-1:0]    ti;
        logic [IDENT_W-1:0] ident;
        logic               switched;
        logic [TOTAL_W-1:0] total;
        logic               dropped;
    } t_res;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_DRAIN,
        BS_FINISH
    } t_bstate;

endpackage

`default_nettype wire

[hw/rtl/tisc_front.sv]
// Front end: takes input requests, drops unused opcodes and queues commands.
// Depends on tisc_pkg.
`default_nettype none

module tisc_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             push,
    output logic                            full,
    input  wire  [1:0]                      i_opcode,
    input  wire  signed [tisc_pkg::POS_W-1:0] i_pos_x,
    input  wire  signed [tisc_pkg::POS_W-1:0] i_pos_y,
    input  wire  signed [tisc_pkg::POS_W-1:0] i_pos_z,
    input  wire  [tisc_pkg::IDENT_W-1:0]    i_track_ident,
    input  wire  [tisc_pkg::TI_W-1:0]       i_truth_index,
    output tisc_pkg::t_cmd                  o_cmd,
    output logic                            o_cmd_valid,
    input  wire                             i_cmd_pop
);
    import tisc_pkg::*;

    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wp, r_rp;
    logic [CQ_AW:0]   r_cnt;
    logic             take, enq, deq;
    t_cmd             cmd_in;

    assign full        = (r_cnt == CQ_AW'(0) + (CQ_AW+1)'(CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // Classify the request; unused opcodes are accepted and discarded.
    always_comb begin
        take = push && !full;
        enq  = take && (i_opcode != OP_SPARE);
        deq  = i_cmd_pop && o_cmd_valid;
        case (i_opcode)
            OP_CLEAR: cmd_in.kind = CMD_CLEAR;
            OP_ADD:   cmd_in.kind = CMD_ADD;
            default:  cmd_in.kind = CMD_EVAL;
        endcase
        cmd_in.x     = i_pos_x;
        cmd_in.y     = i_pos_y;
        cmd_in.z     = i_pos_z;
        cmd_in.ident = i_track_ident;
        cmd_in.ti    = i_truth_index;
    end

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (deq) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({enq, deq})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tisc_back.sv]
// Back end: track store, pipelined nearest-track scan and switch bookkeeping.
// Depends on tisc_pkg.
`default_nettype none

module tisc_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  tisc_pkg::t_cmd                 i_cmd,
    input  wire                            i_cmd_valid,
    output logic                           o_cmd_pop,
    input  wire  [tisc_pkg::CUT_W-1:0]     i_cutoff_sq,
    input  wire  [tisc_pkg::TCNT_W-1:0]    i_truth_count,
    output tisc_pkg::t_res                 o_res,
    output logic                           o_res_push,
    input  wire                            i_res_full
);
    import tisc_pkg::*;

    // Track store and last identity per truth object.
    logic [ENTRY_W-1:0]  r_store [MAX_TRACKS];
    logic [ENTRY_W-1:0]  r_rd;
    logic [IDENT_W-1:0]  r_prev_mem [MAX_TRUTH];
    logic [IDENT_W-1:0]  r_prev_rd;
    logic [MAX_TRUTH-1:0] r_prev_vld;

    t_bstate r_state, n_state;
    logic [TRK_CW-1:0]   r_count, r_k, r_n;
    logic                r_dropped;
    logic [TOTAL_W-1:0]  r_total;
    logic signed [POS_W-1:0] r_ex, r_ey, r_ez;
    logic [TI_W-1:0]     r_ti;
    logic [CUT_W-1:0]    r_best;
    logic [IDENT_W-1:0]  r_best_id;

    // Scan pipeline registers.
    logic                r_v1, r_v2, r_v3, r_v4;
    logic [DIFF_W-1:0]   r_dx, r_dy, r_dz;
    logic [IDENT_W-1:0]  r_id2, r_id3, r_id4;
    logic [SQ_W-1:0]     r_sx, r_sy, r_sz;
    logic [CUT_W-1:0]    r_sum;

    logic                take, issue, finish, pipe_busy, ok;
    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [IDENT_W-1:0]  prev_id;
    logic                sw;
    logic [TOTAL_W-1:0]  total_next;
    logic [TI_W-1:0]     rd_ti;

    assign pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign ok        = ({1'b0, i_cmd.ti} < i_truth_count);
    assign rd_ti     = i_cmd.ti;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == CMD_EVAL) begin
                    n_state = BS_SCAN;
                end
            end
            BS_SCAN: begin
                if (r_k == r_n) begin
                    n_state = BS_DRAIN;
                end
            end
            BS_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = BS_FINISH;
                end
            end
            BS_FINISH: begin
                if (!i_res_full) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        take   = 1'b0;
        issue  = 1'b0;
        finish = 1'b0;
        case (r_state)
            BS_IDLE:   take   = i_cmd_valid;
            BS_SCAN:   issue  = (r_k != r_n);
            BS_DRAIN:  ;
            BS_FINISH: finish = !i_res_full;
            default:   ;
        endcase
    end

    assign o_cmd_pop  = take;
    assign o_res_push = finish;

    // Switch decision on the finished search.
    always_comb begin
        prev_id    = r_prev_vld[r_ti] ? r_prev_rd : '0;
        sw         = (prev_id != '0) && (r_best_id != '0) && (r_best_id != prev_id);
        total_next = (sw && r_total != '1) ? r_total + 1'b1 : r_total;
        o_res.ti       = r_ti;
        o_res.ident    = r_best_id;
        o_res.switched = sw;
        o_res.total    = total_next;
        o_res.dropped  = r_dropped;
    end

    // Distance differences, signed over one extra bit.
    always_comb begin
        dx = DIFF_W'(r_ex) - DIFF_W'($signed(r_rd[ENTRY_W-1 -: POS_W]));
        dy = DIFF_W'(r_ey) - DIFF_W'($signed(r_rd[ENTRY_W-1-POS_W -: POS_W]));
        dz = DIFF_W'(r_ez) - DIFF_W'($signed(r_rd[ENTRY_W-1-2*POS_W -: POS_W]));
    end

    // Store write and registered reads.
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.kind == CMD_ADD && r_count != TRK_CW'(MAX_TRACKS)) begin
            r_store[r_count[TRK_AW-1:0]] <= {i_cmd.x, i_cmd.y, i_cmd.z, i_cmd.ident};
        end
        r_rd <= r_store[r_k[TRK_AW-1:0]];
        if (finish && r_best_id != '0) begin
            r_prev_mem[r_ti] <= r_best_id;
        end
        if (take) begin
            r_prev_rd <= r_prev_mem[rd_ti];
        end
    end

    // Scan datapath: absolute differences, squares, sum.
    always_ff @(posedge i_clk) begin
        r_dx  <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        r_dy  <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        r_dz  <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
        r_id2 <= r_rd[IDENT_W-1:0];
        r_sx  <= r_dx * r_dx;
        r_sy  <= r_dy * r_dy;
        r_sz  <= r_dz * r_dz;
        r_id3 <= r_id2;
        r_sum <= CUT_W'(r_sx) + CUT_W'(r_sy) + CUT_W'(r_sz);
        r_id4 <= r_id3;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_count    <= '0;
            r_dropped  <= 1'b0;
            r_total    <= '0;
            r_prev_vld <= '0;
            r_k        <= '0;
            r_n        <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            if (issue) begin
                r_k <= r_k + 1'b1;
            end
            if (take) begin
                case (i_cmd.kind)
                    CMD_CLEAR: r_count <= '0;
                    CMD_ADD: begin
                        if (r_count != TRK_CW'(MAX_TRACKS)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                    CMD_EVAL: begin
                        r_k <= '0;
                        r_n <= ok ? r_count : '0;
                    end
                    default: ;
                endcase
            end
            if (finish) begin
                r_total <= total_next;
                if (r_best_id != '0) begin
                    r_prev_vld[r_ti] <= 1'b1;
                end
            end
        end
    end

    // Evaluation operands and running best.
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.kind == CMD_EVAL) begin
            r_ex      <= i_cmd.x;
            r_ey      <= i_cmd.y;
            r_ez      <= i_cmd.z;
            r_ti      <= i_cmd.ti;
            r_best    <= i_cutoff_sq;
            r_best_id <= '0;
        end else if (r_v4 && r_sum < r_best) begin
            r_best    <= r_sum;
            r_best_id <= r_id4;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tisc_res_queue.sv]
// Result queue between the back end and the result ports.
// Depends on tisc_pkg.
`default_nettype none

module tisc_res_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  tisc_pkg::t_res  i_res,
    input  wire             i_push,
    output logic            o_full,
    output tisc_pkg::t_res  o_res,
    output logic            empty,
    input  wire             pop
);
    import tisc_pkg::*;

    t_res        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        enq, deq;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign o_res  = r_q[r_rp];
    assign enq    = i_push && !o_full;
    assign deq    = pop && !empty;

    // Payload.
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= i_res;
        end
    end

    // Pointers and fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (enq) begin
                r_wp <= !r_wp;
            end
            if (deq) begin
                r_rp <= !r_rp;
            end
            case ({enq, deq})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/track_id_switch_counter_unit.sv]
// Top level of the track identity switch counter: configuration registers,
// front end, back end and result queue. Depends on tisc_pkg and its modules.
`default_nettype none

// Requests enter through a four-deep command queue. Clear and add requests
// are taken directly from the back end's idle state. An evaluate request
// walks every stored track (none if its truth index is not below the truth
// count) through a distance pipeline of store read, absolute difference,
// square and sum, fed by one store read port. One evaluation runs at a time.
// Results wait in a two-deep queue, and the front keeps accepting while
// results are held until the command queue fills. Configuration writes are
// always ready and should be made while the block is idle.
module track_id_switch_counter_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              push,
    output logic                             full,
    input  wire  [1:0]                       i_opcode,
    input  wire  signed [tisc_pkg::POS_W-1:0] i_pos_x,
    input  wire  signed [tisc_pkg::POS_W-1:0] i_pos_y,
    input  wire  signed [tisc_pkg::POS_W-1:0] i_pos_z,
    input  wire  [tisc_pkg::IDENT_W-1:0]     i_track_ident,
    input  wire  [tisc_pkg::TI_W-1:0]        i_truth_index,
    output logic                             empty,
    input  wire                              pop,
    output logic [tisc_pkg::TI_W-1:0]        o_out_truth_index,
    output logic [tisc_pkg::IDENT_W-1:0]     o_matched_ident,
    output logic                             o_switched,
    output logic [tisc_pkg::TOTAL_W-1:0]     o_switch_total,
    output logic                             o_tracks_dropped,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [1:0]                       i_cfg_index,
    input  wire  [63:0]                      i_cfg_data
);
    import tisc_pkg::*;

    logic [CUT_W-1:0]  r_cutoff_sq;
    logic [TCNT_W-1:0] r_truth_count;
    t_cmd cmd;
    logic cmd_valid, cmd_pop;
    t_res res_in, res_out;
    logic res_push, res_full;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq   <= '0;
            r_truth_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CUTOFF: r_cutoff_sq   <= i_cfg_data[CUT_W-1:0];
                REG_TCOUNT: r_truth_count <= i_cfg_data[TCNT_W-1:0];
                default: ;
            endcase
        end
    end

    tisc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_track_ident (i_track_ident),
        .i_truth_index (i_truth_index),
        .o_cmd         (cmd),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_pop     (cmd_pop)
    );

    tisc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .i_cutoff_sq   (r_cutoff_sq),
        .i_truth_count (r_truth_count),
        .o_res         (res_in),
        .o_res_push    (res_push),
        .i_res_full    (res_full)
    );

    tisc_res_queue u_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res_in),
        .i_push  (res_push),
        .o_full  (res_full),
        .o_res   (res_out),
        .empty   (empty),
        .pop     (pop)
    );

    // Result ports.
    assign o_out_truth_index = res_out.ti;
    assign o_matched_ident   = res_out.ident;
    assign o_switched        = res_out.switched;
    assign o_switch_total    = res_out.total;
    assign o_tracks_dropped  = res_out.dropped;

`ifndef SYNTH
    // The back end never offers a result to a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_push && res_full)) else $error("result offered to full queue");

    // A result written to the queue is visible on the next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |=> !empty) else $error("result lost after push");

    // The back end only takes a command that is present.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid) else $error("command taken from empty queue");
`endif

endmodule

`default_nettype wire
